/* hdl/trps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package trps_pkg;

   localparam int PATCH_SIZE    = 2;
   localparam int WINDOW_DEPTH  = 4;
   localparam int CHANNEL_COUNT = 96;
   localparam int MAX_PATCHES   = 77;

   localparam int ADC_W        = 12;
   localparam int PATCH_W      = 7;
   localparam int SUM_W        = 14;
   localparam int TIME_W       = 16;
   localparam int CHAN_ADDR_W  = $clog2(CHANNEL_COUNT);
   localparam int PATCH_ADDR_W = $clog2(MAX_PATCHES);
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
   localparam int SQ_COUNT     = PATCH_SIZE * PATCH_SIZE;
   localparam int SQ_CNT_W     = $clog2(SQ_COUNT + 1);
   localparam int TOTAL_W      = SUM_W + 4;

   localparam int ACTIVE_FULL  = (MAX_PATCHES < 77) ? MAX_PATCHES : 77;
   localparam int ACTIVE_THIRD = (MAX_PATCHES < 69) ? MAX_PATCHES : 69;
   localparam int LAST_CHANNEL = 95;
   localparam int STRIDE_FULL  = 8;
   localparam int STRIDE_THIRD = 24;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_EVAL  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic REG_SIDE = 1'b0;
   localparam logic REG_SIZE = 1'b1;

   typedef struct packed {
      logic                   wr_en;
      logic [CHAN_ADDR_W-1:0] wr_addr;
      logic [ADC_W-1:0]       wr_data;
      logic                   rd_en;
      logic                   rd_ok;
      logic [CHAN_ADDR_W-1:0] rd_addr;
      logic                   clear;
   } chan_ctrl_type;

   typedef struct packed {
      logic [WINDOW_DEPTH-1:0][SUM_W-1:0] entry;
      logic [FILL_W-1:0]                  fill;
   } win_row_type;

   typedef struct packed {
      logic                    rd_en;
      logic                    wr_en;
      logic [PATCH_ADDR_W-1:0] addr;
      win_row_type             wr_row;
      logic                    clear;
   } win_ctrl_type;

endpackage

`default_nettype wire

/* hdl/trps_chan_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module trps_chan_store
   import trps_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire chan_ctrl_type    ctrl,
   output logic [ADC_W-1:0]      rd_value
);

   logic [ADC_W-1:0]         mem [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] valid_ff;
   logic [ADC_W-1:0]         q_ff;
   logic                     hit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en && ctrl.rd_ok) begin
         q_ff <= mem[ctrl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         valid_ff[ctrl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctrl.rd_en) begin
         hit_ff <= ctrl.rd_ok && valid_ff[ctrl.rd_addr];
      end
   end

   assign rd_value = hit_ff ? q_ff : '0;

endmodule

`default_nettype wire

/* hdl/trps_win_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module trps_win_store
   import trps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire win_ctrl_type  ctrl,
   output win_row_type        rd_row
);

   win_row_type            mem [MAX_PATCHES];
   logic [MAX_PATCHES-1:0] valid_ff;
   win_row_type            q_ff;
   logic                   hit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.addr] <= ctrl.wr_row;
      end
      if (ctrl.rd_en) begin
         q_ff <= mem[ctrl.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         valid_ff[ctrl.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctrl.rd_en) begin
         hit_ff <= valid_ff[ctrl.addr];
      end
   end

   assign rd_row = hit_ff ? q_ff : '0;

endmodule

`default_nettype wire

/* hdl/trigger_patch_sum_timesum.sv */
`timescale 1ns / 1ps
`default_nettype none

// Trigger region unit. Load transactions store the newest ADC count of a channel, clear
// transactions empty every store at once, and evaluate transactions sum a patch's square
// of channels, push that sum into the patch's time window and return one result with the
// window total, or only a flagged result for a patch out of range. Loads, clears and
// unused commands finish in the cycle of acceptance. An evaluate reads each channel of
// the square in turn from the channel memory, drains the last read, then updates the
// window row, read from its memory in the cycle of acceptance. A result waiting in the
// output register does not block loads or clears; a new evaluate waits only at its end.
module trigger_patch_sum_timesum
   import trps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[1:0], channel_index[8:2], channel_adc[20:9], patch_index[27:21]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // patch_echo[6:0], patch_sum[20:7], time_sum[36:21], dropped_sum[50:37],
   // dropped_valid[51], bad_patch[52]
   output logic [55:0]      rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata
);

   typedef struct packed {
      logic [3:0]         pad;
      logic [PATCH_W-1:0] patch;
      logic [ADC_W-1:0]   adc;
      logic [6:0]         chan;
      logic [1:0]         cmd;
   } req_data_type;

   typedef struct packed {
      logic [2:0]         pad;
      logic               bad;
      logic               dvalid;
      logic [SUM_W-1:0]   dropped;
      logic [TIME_W-1:0]  total;
      logic [SUM_W-1:0]   sum;
      logic [PATCH_W-1:0] echo;
   } rsp_data_type;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Reciprocals that give the exact quotient by 7 and by 23 for every 7-bit patch index.
   localparam logic [17:0] RECIP_FULL  = 18'd147;
   localparam logic [17:0] RECIP_THIRD = 18'd179;

   req_data_type  req;
   rsp_data_type  rsp_ff;
   rsp_data_type  rsp_in;
   chan_ctrl_type chan_ctrl;
   win_ctrl_type  win_ctrl;
   win_row_type   old_row;
   win_row_type   new_row;

   logic [1:0]            state_ff, state_in;
   logic                  side_ff, size_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PATCH_W-1:0]    patch_ff, patch_in;
   logic                  bad_ff, bad_in;
   logic [7:0]            seed_ff, seed_in;
   logic [SQ_CNT_W-1:0]   k_ff, k_in;
   logic [SUM_W-1:0]      acc_ff, acc_in;

   logic                  accept;
   logic                  out_free;
   logic [ADC_W-1:0]      chan_value;
   logic [17:0]           prod_full, prod_third;
   logic [4:0]            quot;
   logic                  bad_now;
   logic [4:0]            stride;
   logic [8:0]            offset;
   logic [8:0]            square_pos;
   logic [SUM_W-1:0]      dropped;
   logic [TOTAL_W-1:0]    total;

   assign req        = req_data_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= 1'b0;
         size_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_SIDE: side_ff <= csr_wdata;
            REG_SIZE: size_ff <= csr_wdata;
            default:  side_ff <= side_ff;
         endcase
      end
   end

   assign prod_full  = 18'(req.patch) * RECIP_FULL;
   assign prod_third = 18'(req.patch) * RECIP_THIRD;
   assign quot       = size_ff ? prod_third[16:12] : prod_full[14:10];
   assign bad_now    = size_ff ? (32'(req.patch) >= ACTIVE_THIRD)
                               : (32'(req.patch) >= ACTIVE_FULL);

   assign stride     = size_ff ? 5'(STRIDE_THIRD) : 5'(STRIDE_FULL);
   assign offset     = 9'(k_ff % PATCH_SIZE) + 9'(k_ff / PATCH_SIZE) * 9'(stride);
   assign square_pos = 9'(seed_ff) + offset;

   always_comb begin
      chan_ctrl         = '0;
      chan_ctrl.wr_addr = req.chan[CHAN_ADDR_W-1:0];
      chan_ctrl.wr_data = req.adc;
      chan_ctrl.rd_ok   = square_pos < 9'(CHANNEL_COUNT);
      chan_ctrl.rd_addr = side_ff ? CHAN_ADDR_W'(9'(LAST_CHANNEL) - square_pos)
                                  : CHAN_ADDR_W'(square_pos);
      win_ctrl          = '0;
      win_ctrl.addr     = patch_ff[PATCH_ADDR_W-1:0];
      win_ctrl.wr_row   = new_row;

      state_in     = state_ff;
      patch_in     = patch_ff;
      bad_in       = bad_ff;
      seed_in      = seed_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.cmd)
                  CMD_LOAD: begin
                     chan_ctrl.wr_en = 32'(req.chan) < CHANNEL_COUNT;
                  end
                  CMD_CLEAR: begin
                     chan_ctrl.clear = 1'b1;
                     win_ctrl.clear  = 1'b1;
                  end
                  CMD_EVAL: begin
                     patch_in       = req.patch;
                     bad_in         = bad_now;
                     seed_in        = 8'(req.patch) + 8'(quot);
                     k_in           = '0;
                     acc_in         = '0;
                     win_ctrl.addr  = req.patch[PATCH_ADDR_W-1:0];
                     win_ctrl.rd_en = !bad_now;
                     state_in       = bad_now ? ST_DONE : ST_SUM;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SUM: begin
            chan_ctrl.rd_en = k_ff < SQ_CNT_W'(SQ_COUNT);
            if (k_ff != '0) begin
               acc_in = acc_ff + SUM_W'(chan_value);
            end
            k_in = k_ff + 1'b1;
            if (k_ff == SQ_CNT_W'(SQ_COUNT)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.echo    = patch_ff;
               rsp_in.bad     = bad_ff;
               if (!bad_ff) begin
                  win_ctrl.wr_en = 1'b1;
                  rsp_in.sum     = acc_ff;
                  rsp_in.total   = (total > TOTAL_W'({TIME_W{1'b1}}))
                                   ? {TIME_W{1'b1}} : TIME_W'(total);
                  rsp_in.dropped = dropped;
                  rsp_in.dvalid  = old_row.fill == FILL_W'(WINDOW_DEPTH);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      new_row          = old_row;
      new_row.entry[0] = acc_ff;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
         new_row.entry[i] = old_row.entry[i-1];
      end
      new_row.fill = (old_row.fill == FILL_W'(WINDOW_DEPTH)) ? old_row.fill
                                                             : old_row.fill + 1'b1;
      dropped = (old_row.fill == FILL_W'(WINDOW_DEPTH)) ? old_row.entry[WINDOW_DEPTH-1]
                                                        : '0;
      total = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         total = total + TOTAL_W'(new_row.entry[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      patch_ff <= patch_in;
      bad_ff   <= bad_in;
      seed_ff  <= seed_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

   trps_chan_store u_chan_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (chan_ctrl),
      .rd_value (chan_value)
   );

   trps_win_store u_win_store (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (win_ctrl),
      .rd_row (old_row)
   );

endmodule

`default_nettype wire
